>>> src/murmurhash64a_stream_top_macros.svh
// assertion helpers for the hash stream block
`ifndef MURMURHASH64A_STREAM_TOP_MACROS_SVH
`define MURMURHASH64A_STREAM_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define MH_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define MH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mh64a_pkg.sv
`timescale 1ns / 1ps

package mh64a_pkg;

  // hash constants
  localparam logic [63:0] MurM      = 64'hc6a4a7935bd1e995;
  localparam int unsigned MurR      = 47;
  localparam logic [63:0] SeedReset = 64'h00000000EE6B27EB;

  // message length counter width
  localparam int unsigned LenW = 16;

  // stream field layout
  localparam int unsigned WordW   = 64;
  localparam int unsigned NbW     = 4;
  localparam int unsigned MlenW   = 16;
  localparam int unsigned InDataW = 88;

  // multiplier step codes, three partial products per 64-bit product
  localparam logic [1:0] StepLoLo = 2'd0;
  localparam logic [1:0] StepLoHi = 2'd1;
  localparam logic [1:0] StepHiLo = 2'd2;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEED = 7'b0000010,
    ST_DISP = 7'b0000100,
    ST_K1   = 7'b0001000,
    ST_K2   = 7'b0010000,
    ST_ACC  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } mh_state_e;

  // x ^ (x >> r)
  function automatic logic [63:0] xorshift(input logic [63:0] x);
    return x ^ (x >> MurR);
  endfunction

endpackage

>>> src/murmurhash64a_stream_top.sv
// sequence: the first word of a message is seeded first in SEED; a full word then runs DISP, K1,
//   K2, ACC, a partial word DISP, ACC, an empty word DISP only, and the last word adds FIN for
//   finalization and then the load of the output register, which also holds off the next transfer
// flow: a new transfer is taken only in IDLE, once the previous word is through; the single
//   32x32 multiplier needs three passes per 64-bit product, three products per block
// reset: asynchronous active low; seed returns to 0xEE6B27EB, no message in progress
`timescale 1ns / 1ps
`include "murmurhash64a_stream_top_macros.svh"

module murmurhash64a_stream_top
  import mh64a_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         cfg_we_i,
  input  logic [63:0]  cfg_wdata_i,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [87:0]  s_axis_tdata,   // word[63:0], valid_bytes[67:64], message_len[83:68]
  input  logic         s_axis_tlast,   // last
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // hash[63:0]
  output logic         m_axis_tuser    // length_mismatch[0]
);

  mh_state_e st_q, st_d;
  logic [1:0]      step_q, step_d;
  logic [63:0]     seed_q;
  logic            in_msg_q, in_msg_d;
  logic [LenW-1:0] bytes_q, bytes_d;
  logic [LenW-1:0] stated_q, stated_d;
  logic            err_q, err_d;
  logic            flag_q, flag_d;
  logic            done_q, done_d;
  logic [63:0]     acc_q, acc_d;
  logic [63:0]     op_q, op_d;
  logic [63:0]     prod_q, prod_d;
  logic [63:0]     word_q, word_d;
  logic [3:0]      nb_q, nb_d;
  logic            last_q, last_d;
  logic            m_valid_q, m_valid_d;
  logic [63:0]     m_hash_q, m_hash_d;
  logic            m_flag_q, m_flag_d;

  logic            in_xfer;
  logic [63:0]     in_word;
  logic [3:0]      in_nb_raw, in_nb;
  logic [LenW-1:0] in_mlen;
  logic [LenW-1:0] base_bytes;
  logic            base_err;
  logic [LenW:0]   bytes_sum;
  logic [LenW-1:0] bytes_new;
  logic            err_new;
  logic [LenW-1:0] stated_new;
  logic            mul_state;
  logic            mul_done;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     pp;
  logic [63:0]     mul_sum;
  logic [63:0]     byte_mask;
  logic            out_free;

  // unpack the input transfer
  assign in_word   = s_axis_tdata[63:0];
  assign in_nb_raw = s_axis_tdata[67:64];
  assign in_mlen   = s_axis_tdata[68 +: LenW];
  assign in_nb     = (in_nb_raw > 4'd8) ? 4'd8 : in_nb_raw;

  assign s_axis_tready = (st_q == ST_IDLE) && !done_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  // byte count and error tracking for the incoming word
  always_comb begin
    base_bytes = in_msg_q ? bytes_q : '0;
    base_err   = in_msg_q ? err_q : 1'b0;
    stated_new = in_msg_q ? stated_q : in_mlen;
    bytes_sum  = {1'b0, base_bytes} + (LenW + 1)'(in_nb);
    err_new    = base_err;
    if (bytes_sum[LenW]) begin
      bytes_new = '1;
      err_new   = 1'b1;
    end else begin
      bytes_new = bytes_sum[LenW-1:0];
    end
    if (in_nb != 4'd8 && in_nb != 4'd0 && !s_axis_tlast) begin
      err_new = 1'b1;
    end
  end

  // keep mask for a partial word
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[i*8 +: 8] = (4'(i) < nb_q) ? 8'hff : 8'h00;
    end
  end

  // shared 32x32 multiplier, builds the low 64 bits of op_q * M in three steps
  assign mul_state = (st_q == ST_SEED) || (st_q == ST_K1) || (st_q == ST_K2) ||
                     (st_q == ST_ACC) || (st_q == ST_FIN);
  assign mul_done  = mul_state && (step_q == StepHiLo);

  always_comb begin
    case (step_q)
      StepLoLo: begin
        mul_a = op_q[31:0];
        mul_b = MurM[31:0];
      end
      StepLoHi: begin
        mul_a = op_q[31:0];
        mul_b = MurM[63:32];
      end
      default: begin
        mul_a = op_q[63:32];
        mul_b = MurM[31:0];
      end
    endcase
  end

  assign pp = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    if (step_q == StepLoLo) begin
      mul_sum = pp;
    end else begin
      mul_sum = prod_q + {pp[31:0], 32'd0};
    end
  end

  // sequencer
  always_comb begin
    st_d      = st_q;
    step_d    = step_q;
    in_msg_d  = in_msg_q;
    bytes_d   = bytes_q;
    stated_d  = stated_q;
    err_d     = err_q;
    flag_d    = flag_q;
    done_d    = done_q;
    acc_d     = acc_q;
    op_d      = op_q;
    prod_d    = prod_q;
    word_d    = word_q;
    nb_d      = nb_q;
    last_d    = last_q;
    m_valid_d = m_valid_q;
    m_hash_d  = m_hash_q;
    m_flag_d  = m_flag_q;

    if (m_axis_tvalid && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (mul_state) begin
      prod_d = mul_sum;
      step_d = mul_done ? StepLoLo : step_q + 2'd1;
    end

    case (st_q)
      ST_IDLE: begin
        // hand a finished hash to the output register
        if (done_q && out_free) begin
          m_valid_d = 1'b1;
          m_hash_d  = acc_q;
          m_flag_d  = flag_q;
          done_d    = 1'b0;
        end else if (in_xfer) begin
          word_d   = in_word;
          nb_d     = in_nb;
          last_d   = s_axis_tlast;
          bytes_d  = bytes_new;
          err_d    = err_new;
          stated_d = stated_new;
          flag_d   = err_new || (bytes_new != stated_new);
          in_msg_d = !s_axis_tlast;
          if (!in_msg_q) begin
            op_d = 64'(in_mlen);
            st_d = ST_SEED;
          end else begin
            st_d = ST_DISP;
          end
        end
      end
      ST_SEED: begin
        if (mul_done) begin
          acc_d = seed_q ^ mul_sum;
          st_d  = ST_DISP;
        end
      end
      ST_DISP: begin
        if (nb_q == 4'd8) begin
          op_d = word_q;
          st_d = ST_K1;
        end else if (nb_q != 4'd0) begin
          op_d = acc_q ^ (word_q & byte_mask);
          st_d = ST_ACC;
        end else if (last_q) begin
          op_d = xorshift(acc_q);
          st_d = ST_FIN;
        end else begin
          st_d = ST_IDLE;
        end
      end
      ST_K1: begin
        if (mul_done) begin
          op_d = xorshift(mul_sum);
          st_d = ST_K2;
        end
      end
      ST_K2: begin
        if (mul_done) begin
          op_d = acc_q ^ mul_sum;
          st_d = ST_ACC;
        end
      end
      ST_ACC: begin
        if (mul_done) begin
          acc_d = mul_sum;
          if (last_q) begin
            op_d = xorshift(mul_sum);
            st_d = ST_FIN;
          end else begin
            st_d = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (mul_done) begin
          acc_d  = xorshift(mul_sum);
          done_d = 1'b1;
          st_d   = ST_IDLE;
        end
      end
      default: begin
        st_d   = ST_IDLE;
        step_d = StepLoLo;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      step_q    <= StepLoLo;
      seed_q    <= SeedReset;
      in_msg_q  <= 1'b0;
      bytes_q   <= '0;
      stated_q  <= '0;
      err_q     <= 1'b0;
      done_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      step_q    <= step_d;
      in_msg_q  <= in_msg_d;
      bytes_q   <= bytes_d;
      stated_q  <= stated_d;
      err_q     <= err_d;
      done_q    <= done_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    flag_q   <= flag_d;
    acc_q    <= acc_d;
    op_q     <= op_d;
    prod_q   <= prod_d;
    word_q   <= word_d;
    nb_q     <= nb_d;
    last_q   <= last_d;
    m_hash_q <= m_hash_d;
    m_flag_q <= m_flag_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_hash_q;
  assign m_axis_tuser  = m_flag_q;

  // checks
  `MH_ASSERT(a_step_in_mul, step_q != StepLoLo, mul_state, "multiplier step outside a product")
  `MH_ASSERT_NEXT(a_last_ends_msg, in_xfer && s_axis_tlast, !in_msg_q, "message still open after last")
  `MH_ASSERT_NEXT(a_result_loads, st_q == ST_IDLE && done_q && out_free, m_valid_q && !done_q, "finished hash not loaded")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;

  // mixing constants of the 64-bit hash
  localparam logic [63:0] MIX_MULT   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MIX_SHIFT  = 47;
  localparam logic [63:0] SEED_AFTER_RESET = 64'h00000000EE6B27EB;
  localparam logic [15:0] LEN_CEIL   = 16'hFFFF;
  localparam logic [3:0]  FULL_BLOCK = 4'd8;

  // cycles to let the block settle before a seed write and at the end
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_ITEMS  = 1630;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [63:0] hash;
    logic        mismatch;
  } digest_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        lst;
    logic [15:0] mlen;
    logic        flag;
  } stim_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [63:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata;   // word[63:0], valid_bytes[67:64], message_len[83:68]
  logic         s_axis_tlast;   // last
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;   // hash[63:0]
  logic         m_axis_tuser;   // length_mismatch[0]

  // hash state as the block should hold it
  logic [63:0]  seed_reg;
  logic [63:0]  mix_acc;
  logic [15:0]  byte_count;
  logic [15:0]  stated_len;
  logic         msg_open;
  logic         len_err;

  digest_t      digest_q[$];
  stim_row_t    plan_rows[0:19];
  int           bad_count;
  int           burst_left;
  int           items_fed;

  murmurhash64a_stream_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // fold one accepted word into the running hash, queue the digest on last
  task automatic absorb_word(input logic [63:0] word, input logic [3:0] nb_in,
                             input logic lst, input logic [15:0] mlen,
                             input logic flag_known, input logic flag_val);
    logic [3:0]  nb;
    logic [63:0] k;
    logic [63:0] h;
    logic [63:0] mask;
    logic [16:0] sum;
    digest_t     d;
    nb = (nb_in > FULL_BLOCK) ? FULL_BLOCK : nb_in;
    if (!msg_open) begin
      msg_open   = 1'b1;
      stated_len = mlen;
      byte_count = '0;
      len_err    = 1'b0;
      mix_acc    = seed_reg ^ ({48'd0, mlen} * MIX_MULT);
    end
    if (nb == FULL_BLOCK) begin
      k = word * MIX_MULT;
      k = k ^ (k >> MIX_SHIFT);
      k = k * MIX_MULT;
      mix_acc = (mix_acc ^ k) * MIX_MULT;
    end else if (nb != 4'd0) begin
      mask = (64'd1 << (nb * 8)) - 64'd1;
      mix_acc = (mix_acc ^ (word & mask)) * MIX_MULT;
      if (!lst) len_err = 1'b1;
    end
    // saturating byte count
    sum = {1'b0, byte_count} + nb;
    if (sum > {1'b0, LEN_CEIL}) begin
      byte_count = LEN_CEIL;
      len_err    = 1'b1;
    end else begin
      byte_count = sum[15:0];
    end
    if (lst) begin
      h = mix_acc ^ (mix_acc >> MIX_SHIFT);
      h = h * MIX_MULT;
      h = h ^ (h >> MIX_SHIFT);
      d.hash     = h;
      d.mismatch = flag_known ? flag_val : (len_err || byte_count != stated_len);
      digest_q.push_back(d);
      msg_open   = 1'b0;
      mix_acc    = '0;
      byte_count = '0;
      stated_len = '0;
      len_err    = 1'b0;
    end
  endtask

  // one input transfer, with bursts and gaps; called and returns at a falling edge
  task automatic push_item(input logic [63:0] word, input logic [3:0] nb,
                           input logic lst, input logic [15:0] mlen,
                           input logic flag_known, input logic flag_val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'd0, mlen, nb, word};
    s_axis_tlast  = lst;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    absorb_word(word, nb, lst, mlen, flag_known, flag_val);
    if (nb != 4'd0 || lst) items_fed++;
    @(negedge clk_i);
  endtask

  // seed write once every expected digest is back
  task automatic load_seed(input logic [63:0] value);
    s_axis_tvalid = 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    seed_reg = value;
  endtask

  // well-formed message: full words, then a partial tail or last full word; one empty word if len is 0
  task automatic send_clean(input int len);
    int n_full;
    int rem;
    logic [3:0] nb;
    n_full = len / 8;
    rem    = len % 8;
    if (len == 0) begin
      push_item({$urandom, $urandom}, 4'd0, 1'b1, 16'(len), 1'b0, 1'b0);
    end else begin
      for (int i = 0; i < n_full; i++) begin
        nb = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : FULL_BLOCK;
        // an empty word adds no bytes, but as the first word it opens the message with a random stated length
        if ($urandom_range(0, 15) == 0)
          push_item({$urandom, $urandom}, 4'd0, 1'b0, 16'($urandom), 1'b0, 1'b0);
        push_item({$urandom, $urandom}, nb, (rem == 0 && i == n_full - 1),
                  16'(len), 1'b0, 1'b0);
      end
      if (rem != 0)
        push_item({$urandom, $urandom}, 4'(rem), 1'b1, 16'(len), 1'b0, 1'b0);
    end
  endtask

  // noise: random byte counts, random stated length
  task automatic send_broken();
    int n;
    logic [15:0] mlen;
    mlen = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 48));
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      push_item({$urandom, $urandom}, 4'($urandom_range(0, 15)), (i == n - 1),
                mlen, 1'b0, 1'b0);
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    digest_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display("%0t: unexpected result hash=%h flag=%b", $realtime,
                   m_axis_tdata, m_axis_tuser);
      end else begin
        want = digest_q.pop_front();
        if (m_axis_tdata !== want.hash || m_axis_tuser !== want.mismatch) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("%0t: hash exp %h got %h, length_mismatch exp %b got %b",
                     $realtime, want.hash, m_axis_tdata, want.mismatch, m_axis_tuser);
        end
      end
    end
  end

  // receiver stalls, switching to a random pattern after each random span
  initial begin : sink_stall
    int mode;
    int span;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0: m_axis_tready = 1'b1;
          1: m_axis_tready = ($urandom_range(0, 1) == 1);
          2: m_axis_tready = ($urandom_range(0, 4) == 0);
          default: m_axis_tready = ~m_axis_tready;
        endcase
      end
    end
  end

  // stimulus
  initial begin : stim_main
    int pick;
    int msg_total;
    int cfg_round;
    logic [63:0] next_seed;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    seed_reg      = SEED_AFTER_RESET;
    mix_acc       = '0;
    byte_count    = '0;
    stated_len    = '0;
    msg_open      = 1'b0;
    len_err       = 1'b0;
    bad_count     = 0;
    burst_left    = 0;
    items_fed     = 0;
    msg_total     = 0;
    cfg_round     = 0;

    // directed rows: word, valid bytes, last, stated length, flag on last
    plan_rows = '{
      // empty message with the reset seed, then empty with a wrong length
      '{64'h0, 4'd0, 1'b1, 16'd0, 1'b0},
      '{64'h0, 4'd0, 1'b1, 16'd5, 1'b1},
      // single full blocks at the word extremes, oversized count as a block
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 16'd8, 1'b0},
      '{64'h0, 4'd8, 1'b1, 16'd8, 1'b0},
      '{64'hA5A5_A5A5_5A5A_5A5A, 4'd15, 1'b1, 16'd8, 1'b0},
      // block plus partial tail
      '{64'h0123_4567_89AB_CDEF, 4'd9, 1'b0, 16'd13, 1'b0},
      '{64'hFEDC_BA98_7654_3210, 4'd5, 1'b1, 16'd0, 1'b0},
      // partial word ahead of the last one
      '{64'hDEAD_BEEF_CAFE_F00D, 4'd3, 1'b0, 16'd11, 1'b0},
      '{64'h1357_9BDF_2468_ACE0, 4'd8, 1'b1, 16'd0, 1'b1},
      // empty words inside and at the end of a message
      '{64'h8000_0000_0000_0001, 4'd8, 1'b0, 16'd16, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 16'd16, 1'b0},
      '{64'h7FFF_FFFF_FFFF_FFFE, 4'd8, 1'b0, 16'd16, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 16'd16, 1'b0},
      // partial masks at both ends
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 16'd7, 1'b0},
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1, 16'd1, 1'b0},
      // largest stated length, count far short
      '{64'hFFFF_FFFF_FFFF_FFFF, 4'd7, 1'b1, 16'hFFFF, 1'b1},
      '{64'h0F0F_0F0F_F0F0_F0F0, 4'd8, 1'b0, 16'hFFFF, 1'b0},
      '{64'h3333_CCCC_5555_AAAA, 4'd4, 1'b1, 16'hABCD, 1'b1},
      // message opened by an empty word
      '{64'h0, 4'd0, 1'b0, 16'd2, 1'b0},
      '{64'h0000_0000_0000_BEEF, 4'd2, 1'b1, 16'd9, 1'b0}
    };

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan_rows[i])
      push_item(plan_rows[i].word, plan_rows[i].nbytes, plan_rows[i].lst,
                plan_rows[i].mlen, plan_rows[i].lst, plan_rows[i].flag);

    // random messages, seed changed between phases
    items_fed = 0;
    while (items_fed < RANDOM_ITEMS) begin
      if (msg_total % 30 == 0) begin
        case (cfg_round % 4)
          0: next_seed = 64'h0;
          1: next_seed = 64'hFFFF_FFFF_FFFF_FFFF;
          2: next_seed = {$urandom, $urandom};
          default: next_seed = SEED_AFTER_RESET;
        endcase
        load_seed(next_seed);
        cfg_round++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_clean($urandom_range(0, 40));
      else if (pick < 82)
        send_clean($urandom_range(41, 300));
      else
        send_broken();
      msg_total++;
    end

    // drain
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (digest_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (bad_count == 0 && digest_q.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/mh64a_pkg.sv
src/murmurhash64a_stream_top.sv
tb/tb.sv
